// File: design/ifbbs_pkg.sv
package ifbbs_pkg;

	// Output stream byte positions for one input item, in send order
	localparam int unsigned NUM_POS = 9;
	localparam int unsigned POS_W = $clog2(NUM_POS);

	localparam logic [POS_W-1:0] P_OPEN_FLAG = POS_W'(0);
	localparam logic [POS_W-1:0] P_ADDR      = POS_W'(1);
	localparam logic [POS_W-1:0] P_CTRL      = POS_W'(2);
	localparam logic [POS_W-1:0] P_HCS       = POS_W'(3);
	localparam logic [POS_W-1:0] P_DATA_ESC  = POS_W'(4);
	localparam logic [POS_W-1:0] P_DATA      = POS_W'(5);
	localparam logic [POS_W-1:0] P_CHK_ESC   = POS_W'(6);
	localparam logic [POS_W-1:0] P_CHK       = POS_W'(7);
	localparam logic [POS_W-1:0] P_CLOSE     = POS_W'(8);

	// Sequence bit position inside the control byte
	localparam int unsigned CTRL_SEQ_SHIFT = 6;

	// APB register map
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FLAG    = 2'd0,
		REG_ESCAPE  = 2'd1,
		REG_MASK    = 2'd2,
		REG_ADDRESS = 2'd3
	} reg_idx_t;

	localparam logic [7:0] FLAG_RST    = 8'd126;
	localparam logic [7:0] ESCAPE_RST  = 8'd125;
	localparam logic [7:0] MASK_RST    = 8'd32;
	localparam logic [7:0] ADDRESS_RST = 8'd3;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] stuff_mask;
		logic [7:0] address_byte;
	} cfg_t;

	// Byte list for one input item: every position plus a mask of those sent
	typedef struct packed {
		logic [NUM_POS-1:0][7:0] bytes;
		logic [NUM_POS-1:0]      send;
	} slot_t;

endpackage

// File: design/ifbbs_in_if.sv
interface ifbbs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       seq_bit;
	logic       last_in;

	modport source (output valid, output data_byte, output seq_bit, output last_in,
		input ready);
	modport sink (input valid, input data_byte, input seq_bit, input last_in,
		output ready);
endinterface

// File: design/ifbbs_out_if.sv
interface ifbbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: design/ifbbs_cfg.sv
module ifbbs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ifbbs_pkg::ADDR_W-1:0] paddr,
	input  logic [ifbbs_pkg::DATA_W-1:0] pwdata,
	output logic [ifbbs_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output ifbbs_pkg::cfg_t              cfg
);

	ifbbs_pkg::cfg_t     cfg_q;
	ifbbs_pkg::reg_idx_t idx;
	logic                wr_en;
	logic [7:0]          rd_val;

	assign pready = 1'b1;
	assign idx    = ifbbs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Register file, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte    <= ifbbs_pkg::FLAG_RST;
			cfg_q.escape_byte  <= ifbbs_pkg::ESCAPE_RST;
			cfg_q.stuff_mask   <= ifbbs_pkg::MASK_RST;
			cfg_q.address_byte <= ifbbs_pkg::ADDRESS_RST;
		end else if (wr_en) begin
			unique case (idx)
				ifbbs_pkg::REG_FLAG:    cfg_q.flag_byte    <= pwdata[7:0];
				ifbbs_pkg::REG_ESCAPE:  cfg_q.escape_byte  <= pwdata[7:0];
				ifbbs_pkg::REG_MASK:    cfg_q.stuff_mask   <= pwdata[7:0];
				ifbbs_pkg::REG_ADDRESS: cfg_q.address_byte <= pwdata[7:0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			ifbbs_pkg::REG_FLAG:    rd_val = cfg_q.flag_byte;
			ifbbs_pkg::REG_ESCAPE:  rd_val = cfg_q.escape_byte;
			ifbbs_pkg::REG_MASK:    rd_val = cfg_q.stuff_mask;
			ifbbs_pkg::REG_ADDRESS: rd_val = cfg_q.address_byte;
		endcase
	end

	assign prdata = {{(ifbbs_pkg::DATA_W-8){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule

// File: design/ifbbs_fmt.sv
module ifbbs_fmt (
	input  logic            clk,
	input  logic            arst_n,
	input  ifbbs_pkg::cfg_t cfg,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            seq_bit,
	input  logic            last_in,
	output ifbbs_pkg::slot_t slot
);

	logic       frame_open_q;
	logic [7:0] check_q;
	logic [7:0] ctrl;
	logic [7:0] chk_new;
	logic       data_sp;
	logic       chk_sp;

	// Running check restarts with a new frame
	assign ctrl    = 8'(seq_bit) << ifbbs_pkg::CTRL_SEQ_SHIFT;
	assign chk_new = (frame_open_q ? check_q : 8'd0) ^ data_byte;
	assign data_sp = (data_byte == cfg.flag_byte) || (data_byte == cfg.escape_byte);
	assign chk_sp  = (chk_new == cfg.flag_byte) || (chk_new == cfg.escape_byte);

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			check_q      <= 8'd0;
		end else if (accept) begin
			frame_open_q <= !last_in;
			check_q      <= last_in ? 8'd0 : chk_new;
		end
	end

	// Byte list at fixed positions
	always_comb begin
		slot.bytes = '0;
		slot.send  = '0;
		slot.bytes[ifbbs_pkg::P_OPEN_FLAG] = cfg.flag_byte;
		slot.bytes[ifbbs_pkg::P_ADDR]      = cfg.address_byte;
		slot.bytes[ifbbs_pkg::P_CTRL]      = ctrl;
		slot.bytes[ifbbs_pkg::P_HCS]       = cfg.address_byte ^ ctrl;
		slot.bytes[ifbbs_pkg::P_DATA_ESC]  = cfg.escape_byte;
		slot.bytes[ifbbs_pkg::P_DATA]      = data_sp ? (data_byte ^ cfg.stuff_mask)
			: data_byte;
		slot.bytes[ifbbs_pkg::P_CHK_ESC]   = cfg.escape_byte;
		slot.bytes[ifbbs_pkg::P_CHK]       = chk_sp ? (chk_new ^ cfg.stuff_mask) : chk_new;
		slot.bytes[ifbbs_pkg::P_CLOSE]     = cfg.flag_byte;

		slot.send[ifbbs_pkg::P_OPEN_FLAG] = !frame_open_q;
		slot.send[ifbbs_pkg::P_ADDR]      = !frame_open_q;
		slot.send[ifbbs_pkg::P_CTRL]      = !frame_open_q;
		slot.send[ifbbs_pkg::P_HCS]       = !frame_open_q;
		slot.send[ifbbs_pkg::P_DATA_ESC]  = data_sp;
		slot.send[ifbbs_pkg::P_DATA]      = 1'b1;
		slot.send[ifbbs_pkg::P_CHK_ESC]   = last_in && chk_sp;
		slot.send[ifbbs_pkg::P_CHK]       = last_in;
		slot.send[ifbbs_pkg::P_CLOSE]     = last_in;
	end

endmodule

// File: design/ifbbs_ser.sv
module ifbbs_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  ifbbs_pkg::slot_t slot,
	input  logic             load,
	output logic             ready,
	ifbbs_out_if.source      framed
);

	logic [ifbbs_pkg::NUM_POS-1:0][7:0] bytes_s1;
	logic [ifbbs_pkg::NUM_POS-1:0]      pend_s1;
	logic [ifbbs_pkg::POS_W-1:0]        sel;
	logic                               busy;
	logic                               out_free;
	logic                               emit;
	logic                               last_emit;
	logic                               out_valid_q;
	logic [7:0]                         out_byte_q;
	logic                               out_last_q;

	// Lowest pending position goes next
	always_comb begin
		sel = '0;
		for (int i = ifbbs_pkg::NUM_POS - 1; i >= 0; i--) begin
			if (pend_s1[i]) begin
				sel = ifbbs_pkg::POS_W'(i);
			end
		end
	end

	assign busy      = |pend_s1;
	assign out_free  = !out_valid_q || framed.ready;
	assign emit      = busy && out_free;
	assign last_emit = emit
		&& ((pend_s1 & (pend_s1 - {{(ifbbs_pkg::NUM_POS-1){1'b0}}, 1'b1})) == '0);
	assign ready     = !busy || last_emit;

	// Slot holding the byte list of the item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load) begin
			pend_s1 <= slot.send;
		end else if (emit) begin
			pend_s1[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s1 <= slot.bytes;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (framed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= bytes_s1[sel];
			out_last_q <= (sel == ifbbs_pkg::P_CLOSE);
		end
	end

	assign framed.valid    = out_valid_q;
	assign framed.out_byte = out_byte_q;
	assign framed.out_last = out_last_q;

endmodule

// File: design/info_frame_builder_byte_stuffing_unit.sv
// Channel   Dir  Handshake      Payload
// payload   in   valid/ready    data_byte[7:0], seq_bit, last_in
// framed    out  valid/ready    out_byte[7:0], out_last
// apb       in   psel/penable   paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
// Each payload transaction yields 1 to 9 output bytes, one byte per cycle
// while framed is not stalled; the output byte rate sets throughput. An item is
// formatted into a byte slot in its accept cycle; its first byte then passes
// through the slot register and the output register. The next item is taken in the
// cycle the slot's last byte moves to the output register.
// arst_n clears frame state, slot and output valid; registers return to reset.
// A stall on framed holds the output register and then the slot.
module info_frame_builder_byte_stuffing_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	ifbbs_in_if.sink                     payload,
	ifbbs_out_if.source                  framed,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ifbbs_pkg::ADDR_W-1:0] paddr,
	input  logic [ifbbs_pkg::DATA_W-1:0] pwdata,
	output logic [ifbbs_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);

	ifbbs_pkg::cfg_t  cfg;
	ifbbs_pkg::slot_t slot;
	logic             ready;
	logic             accept;

	assign payload.ready = ready;
	assign accept        = payload.valid && ready;

	ifbbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ifbbs_fmt u_fmt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.data_byte (payload.data_byte),
		.seq_bit   (payload.seq_bit),
		.last_in   (payload.last_in),
		.slot      (slot)
	);

	ifbbs_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.slot   (slot),
		.load   (accept),
		.ready  (ready),
		.framed (framed)
	);

endmodule

// File: design/ifbbs_checker.sv
module ifbbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// A stalled output byte stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// A stalled output byte keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	// Back pressure on the input only while output bytes are on their way
	a_busy_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled with no output byte pending");

	// Accepted item whose slot drains next cycle must have produced a byte
	a_item_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 in_ready |=> out_valid)
		else $error("accepted item produced no output byte");

endmodule

bind info_frame_builder_byte_stuffing_unit ifbbs_checker u_ifbbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (payload.valid),
	.in_ready  (payload.ready),
	.out_valid (framed.valid),
	.out_ready (framed.ready),
	.out_byte  (framed.out_byte),
	.out_last  (framed.out_last)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 50;

	// One byte of the framed stream as the framer should send it
	typedef struct {
		logic [7:0] value;
		logic       closing;
	} wire_byte_t;

	// Directed script line: a register write or a payload byte.
	// Typed-in streams are left-justified: byte i of the stream is lit[8-i].
	typedef struct {
		bit                  is_cfg;
		ifbbs_pkg::reg_idx_t idx;
		logic [7:0]          data;
		logic                seq;
		logic                last;
		int                  lit_n;
		logic [8:0][7:0]     lit;
	} row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ifbbs_pkg::ADDR_W-1:0] paddr;
	logic [ifbbs_pkg::DATA_W-1:0] pwdata;
	logic [ifbbs_pkg::DATA_W-1:0] prdata;
	logic                         pready;

	ifbbs_in_if  payload ();
	ifbbs_out_if framed ();

	info_frame_builder_byte_stuffing_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.framed  (framed),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Framer mirror: register copy, running check byte, open-frame flag
	ifbbs_pkg::cfg_t cfg_now;
	logic [7:0]      run_xor;
	logic            frame_is_open;

	wire_byte_t item_bytes[$];
	wire_byte_t due_bytes[$];

	int mismatches = 0;
	int items_sent = 0;
	int bytes_seen = 0;
	int frames_closed = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_reqs = 0;

	always #4 clk = ~clk;

	// Append one payload-side byte, escaped if it collides with flag or escape
	function automatic void push_stuffed(logic [7:0] b);
		if (b == cfg_now.flag_byte || b == cfg_now.escape_byte) begin
			item_bytes.push_back(wire_byte_t'{cfg_now.escape_byte, 1'b0});
			item_bytes.push_back(wire_byte_t'{b ^ cfg_now.stuff_mask, 1'b0});
		end else begin
			item_bytes.push_back(wire_byte_t'{b, 1'b0});
		end
	endfunction

	// Bytes caused by one payload byte: header if no frame is open, the byte,
	// and on the last one the check byte and closing flag
	function automatic void frame_bytes(logic [7:0] d, logic s, logic l);
		logic [7:0] ctrl;
		ctrl = 8'(s) << ifbbs_pkg::CTRL_SEQ_SHIFT;
		item_bytes.delete();
		if (!frame_is_open) begin
			item_bytes.push_back(wire_byte_t'{cfg_now.flag_byte, 1'b0});
			item_bytes.push_back(wire_byte_t'{cfg_now.address_byte, 1'b0});
			item_bytes.push_back(wire_byte_t'{ctrl, 1'b0});
			item_bytes.push_back(wire_byte_t'{cfg_now.address_byte ^ ctrl, 1'b0});
			run_xor = 8'h00;
			frame_is_open = 1'b1;
		end
		run_xor = run_xor ^ d;
		push_stuffed(d);
		if (l) begin
			push_stuffed(run_xor);
			item_bytes.push_back(wire_byte_t'{cfg_now.flag_byte, 1'b1});
			run_xor = 8'h00;
			frame_is_open = 1'b0;
		end
	endfunction

	function automatic row_t item_row(logic [7:0] d, logic s, logic l, int n = 0,
			logic [8:0][7:0] bytes = '0);
		row_t r;
		r = '{is_cfg: 1'b0, idx: ifbbs_pkg::REG_FLAG, data: d, seq: s, last: l,
			lit_n: n, lit: bytes};
		return r;
	endfunction

	function automatic row_t cfg_row(ifbbs_pkg::reg_idx_t idx, logic [7:0] v);
		row_t r;
		r = '{is_cfg: 1'b1, idx: idx, data: v, seq: 1'b0, last: 1'b0, lit_n: 0, lit: '0};
		return r;
	endfunction

	// Offer one payload byte after an optional gap; returns at its acceptance edge
	task automatic offer_item(logic [7:0] d, logic s, logic l, int lit_n = 0,
			logic [8:0][7:0] lit = '0);
		while ($urandom_range(99) < tx_idle_pct) begin
			payload.valid <= 1'b0;
			@(posedge clk);
		end
		frame_bytes(d, s, l);
		if (lit_n > 0) begin
			for (int i = 0; i < lit_n; i++)
				due_bytes.push_back(wire_byte_t'{lit[8-i], (i == lit_n - 1) && l});
		end else begin
			foreach (item_bytes[i]) due_bytes.push_back(item_bytes[i]);
		end
		payload.valid <= 1'b1;
		payload.data_byte <= d;
		payload.seq_bit <= s;
		payload.last_in <= l;
		@(posedge clk);
		while (!payload.ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering, wait for every expected byte, then let the pipeline settle
	task automatic drain();
		payload.valid <= 1'b0;
		@(posedge clk);
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, then psel low before the task returns
	task automatic write_reg(ifbbs_pkg::reg_idx_t idx, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ifbbs_pkg::REG_FLAG:    cfg_now.flag_byte = v;
			ifbbs_pkg::REG_ESCAPE:  cfg_now.escape_byte = v;
			ifbbs_pkg::REG_MASK:    cfg_now.stuff_mask = v;
			ifbbs_pkg::REG_ADDRESS: cfg_now.address_byte = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_cfg(ifbbs_pkg::cfg_t c);
		write_reg(ifbbs_pkg::REG_FLAG, c.flag_byte);
		write_reg(ifbbs_pkg::REG_ESCAPE, c.escape_byte);
		write_reg(ifbbs_pkg::REG_MASK, c.stuff_mask);
		write_reg(ifbbs_pkg::REG_ADDRESS, c.address_byte);
	endtask

	// Framed-side ready: random stalls, plus long hold-offs on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		framed.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				framed.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
				framed.ready <= 1'b0;
			end else begin
				framed.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Compare each output transaction with the oldest expected byte
	always @(posedge clk) begin : byte_check
		wire_byte_t want;
		if (arst_n && framed.valid && framed.ready) begin
			bytes_seen++;
			if (framed.out_last) frames_closed++;
			if (due_bytes.size() == 0) begin
				$error("unexpected byte %02h (out_last %0b)", framed.out_byte, framed.out_last);
				mismatches++;
			end else begin
				want = due_bytes.pop_front();
				if (framed.out_byte !== want.value) begin
					$error("out_byte: expected %02h, got %02h", want.value, framed.out_byte);
					mismatches++;
				end
				if (framed.out_last !== want.closing) begin
					$error("out_last: expected %0b, got %0b", want.closing, framed.out_last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if ((payload.valid && payload.ready) || (framed.valid && framed.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles", quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t            script[$];
		ifbbs_pkg::cfg_t phase_cfg;
		int              frame_left;
		logic [7:0]      d;

		payload.valid = 1'b0;
		payload.data_byte = 8'h00;
		payload.seq_bit = 1'b0;
		payload.last_in = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_now = '{ifbbs_pkg::FLAG_RST, ifbbs_pkg::ESCAPE_RST, ifbbs_pkg::MASK_RST,
			ifbbs_pkg::ADDRESS_RST};
		run_xor = 8'h00;
		frame_is_open = 1'b0;
		frame_left = 0;

		// Directed script, reset register values first
		script.push_back(item_row(8'h00, 1'b0, 1'b1, 7,
			{8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h7E, 16'h0000}));
		// single byte frame of a flag: payload and check byte both escaped
		script.push_back(item_row(8'h7E, 1'b1, 1'b1, 9,
			{8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E, 8'h7D, 8'h5E, 8'h7E}));
		// seq bit ignored inside an open frame
		script.push_back(item_row(8'hFF, 1'b1, 1'b0));
		script.push_back(item_row(8'h7D, 1'b0, 1'b0));
		script.push_back(item_row(8'h00, 1'b1, 1'b1));
		// check byte lands on the escape value
		script.push_back(item_row(8'h01, 1'b0, 1'b0));
		script.push_back(item_row(8'h7C, 1'b0, 1'b1));
		// zero mask: escaped byte goes out unchanged, still special
		script.push_back(cfg_row(ifbbs_pkg::REG_MASK, 8'h00));
		script.push_back(item_row(8'h7D, 1'b1, 1'b1));
		// flag equal to escape
		script.push_back(cfg_row(ifbbs_pkg::REG_FLAG, 8'h55));
		script.push_back(cfg_row(ifbbs_pkg::REG_ESCAPE, 8'h55));
		script.push_back(cfg_row(ifbbs_pkg::REG_MASK, 8'hFF));
		script.push_back(cfg_row(ifbbs_pkg::REG_ADDRESS, 8'hFF));
		script.push_back(item_row(8'h55, 1'b1, 1'b0));
		script.push_back(item_row(8'hAA, 1'b0, 1'b1));
		// register change with a frame open
		script.push_back(cfg_row(ifbbs_pkg::REG_FLAG, 8'h00));
		script.push_back(cfg_row(ifbbs_pkg::REG_ESCAPE, 8'hFF));
		script.push_back(cfg_row(ifbbs_pkg::REG_MASK, 8'h80));
		script.push_back(cfg_row(ifbbs_pkg::REG_ADDRESS, 8'h00));
		script.push_back(item_row(8'h00, 1'b0, 1'b0));
		script.push_back(item_row(8'hFF, 1'b1, 1'b0));
		script.push_back(cfg_row(ifbbs_pkg::REG_FLAG, 8'h01));
		script.push_back(cfg_row(ifbbs_pkg::REG_ADDRESS, 8'h80));
		script.push_back(item_row(8'h01, 1'b0, 1'b1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain();
				write_reg(script[i].idx, script[i].data);
			end else begin
				offer_item(script[i].data, script[i].seq, script[i].last,
					script[i].lit_n, script[i].lit);
			end
		end

		// Random phases; frames run across phase boundaries and register writes
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0, 6: phase_cfg = '{ifbbs_pkg::FLAG_RST, ifbbs_pkg::ESCAPE_RST,
					ifbbs_pkg::MASK_RST, ifbbs_pkg::ADDRESS_RST};
				1: phase_cfg = '0;
				2: phase_cfg = '1;
				4: begin
					phase_cfg = ifbbs_pkg::cfg_t'($urandom);
					phase_cfg.escape_byte = phase_cfg.flag_byte;
				end
				default: phase_cfg = ifbbs_pkg::cfg_t'($urandom);
			endcase
			set_cfg(phase_cfg);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (p == 4) hold_reqs++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2) drain();
				if (frame_left == 0)
					frame_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
				case ($urandom_range(9))
					0, 1: d = cfg_now.flag_byte;
					2, 3: d = cfg_now.escape_byte;
					4: d = cfg_now.flag_byte ^ cfg_now.stuff_mask;
					default: d = 8'($urandom);
				endcase
				offer_item(d, 1'($urandom), frame_left == 1);
				frame_left--;
			end
		end

		drain();
		$display("tb: %0d payload bytes in, %0d framed bytes checked, %0d frames closed",
			items_sent, bytes_seen, frames_closed);
		$display("tb: %0d register settings incl. all-zero, all-one and flag == escape",
			PHASES + 3);
		if (mismatches == 0 && due_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
